// ===== hdl/sqmr_pkg.sv =====
// ----------------------------------------------------------------------------
// sqmr_pkg
// Shared sizes, codes and command types for the matrix rotate block.
// ----------------------------------------------------------------------------
package sqmr_pkg;

  // Largest side length held by the element store
  localparam int MAX_SIDE   = 16;
  localparam int DEPTH      = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int POS_W      = $clog2(MAX_SIDE);
  localparam int SIDE_W     = $clog2(MAX_SIDE + 1);

  localparam int DATA_W     = 32;
  localparam int SIZE_W     = 5;
  localparam int SIZE_RESET = 16;

  // Configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] REG_MATRIX_SIZE = 3'd0;

  // Input item kinds carried on tuser
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_FETCH = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic load;     // store the element, advance load count
    logic fetch;    // read the rotated element, advance fetch position
    logic zero_res; // place a not-ready result in the output register
    logic capture;  // move read data into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic full;     // all N*N elements held
  } status_t;

  // Effective side length: zero acts as one, anything too large is clamped
  function automatic logic [SIDE_W-1:0] side_of(logic [SIZE_W-1:0] v);
    logic [SIDE_W-1:0] n;
    if (v == '0) begin
      n = SIDE_W'(1);
    end else if (int'(v) > MAX_SIDE) begin
      n = SIDE_W'(MAX_SIDE);
    end else begin
      n = SIDE_W'(v);
    end
    return n;
  endfunction

endpackage

// ===== hdl/sqmr_ctrl.sv =====
// ----------------------------------------------------------------------------
// sqmr_ctrl
// Handshake control and sequencing of loads and fetches.
// ----------------------------------------------------------------------------
module sqmr_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic             in_func,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  sqmr_pkg::status_t sts,
  output sqmr_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_xfer;

  // Take an item only in the idle state and when the output register is free or draining this cycle
  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_func == sqmr_pkg::FUNC_LOAD) begin
            cmd.load = 1'b1;
          end else if (sts.full) begin
            cmd.fetch = 1'b1;
            state_nxt = ST_READ;
          end else begin
            cmd.zero_res  = 1'b1;
            out_valid_nxt = 1'b1;
          end
        end
      end
      ST_READ: begin
        cmd.capture   = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hdl/sqmr_dp.sv =====
// ----------------------------------------------------------------------------
// sqmr_dp
// Element store, load and fetch counters, size register and output register.
// ----------------------------------------------------------------------------
module sqmr_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  sqmr_pkg::cmd_t                         cmd,
  output sqmr_pkg::status_t                      sts,
  input  logic                                   cfg_wr,
  input  logic [sqmr_pkg::SIZE_W-1:0]            cfg_size,
  output logic [sqmr_pkg::SIZE_W-1:0]            matrix_size,
  input  logic signed [sqmr_pkg::DATA_W-1:0]     load_value,
  output logic signed [sqmr_pkg::DATA_W-1:0]     out_value,
  output logic                                   out_last,
  output logic                                   out_ok
);

  logic [sqmr_pkg::DATA_W-1:0] mem [sqmr_pkg::DEPTH];

  logic [sqmr_pkg::SIZE_W-1:0]  size_r;
  logic [sqmr_pkg::CNT_W-1:0]   load_cnt_r;
  logic [sqmr_pkg::POS_W-1:0]   row_r;
  logic [sqmr_pkg::POS_W-1:0]   col_r;
  logic [sqmr_pkg::ADDR_W-1:0]  addr_r;

  logic [sqmr_pkg::DATA_W-1:0]  rdata_r;
  logic                         last_pend_r;
  logic signed [sqmr_pkg::DATA_W-1:0] value_r;
  logic                         last_r;
  logic                         ok_r;

  logic [sqmr_pkg::SIDE_W-1:0]  side;
  logic [sqmr_pkg::SIDE_W-1:0]  side_m1;
  logic [sqmr_pkg::CNT_W-1:0]   total;
  logic [sqmr_pkg::CNT_W-1:0]   col0_addr;
  logic [sqmr_pkg::ADDR_W-1:0]  rd_addr;
  logic                         row_end;
  logic                         col_end;
  logic                         last;
  logic                         full;

  assign side    = sqmr_pkg::side_of(size_r);
  assign side_m1 = side - sqmr_pkg::SIDE_W'(1);
  assign total   = sqmr_pkg::CNT_W'(side) * sqmr_pkg::CNT_W'(side);
  assign full    = (load_cnt_r >= total);

  // Rotated (r, c) sits at original (N-1-c, r): column zero starts at
  // (N-1)*N + r and each further column steps back by N.
  assign col0_addr = total - sqmr_pkg::CNT_W'(side) + sqmr_pkg::CNT_W'(row_r);
  assign rd_addr   = (col_r == '0) ? col0_addr[sqmr_pkg::ADDR_W-1:0] : addr_r;
  assign row_end   = (sqmr_pkg::SIDE_W'(row_r) == side_m1);
  assign col_end   = (sqmr_pkg::SIDE_W'(col_r) == side_m1);
  assign last      = row_end && col_end;

  assign sts.full    = full;
  assign matrix_size = size_r;
  assign out_value   = value_r;
  assign out_last    = last_r;
  assign out_ok      = ok_r;

  // Size register and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r     <= sqmr_pkg::SIZE_W'(sqmr_pkg::SIZE_RESET);
      load_cnt_r <= '0;
      row_r      <= '0;
      col_r      <= '0;
    end else if (cfg_wr) begin
      size_r     <= cfg_size;
      load_cnt_r <= '0;
      row_r      <= '0;
      col_r      <= '0;
    end else if (cmd.load && !full) begin
      load_cnt_r <= load_cnt_r + sqmr_pkg::CNT_W'(1);
    end else if (cmd.fetch) begin
      if (last) begin
        load_cnt_r <= '0;
        row_r      <= '0;
        col_r      <= '0;
      end else if (col_end) begin
        col_r <= '0;
        row_r <= row_r + sqmr_pkg::POS_W'(1);
      end else begin
        col_r <= col_r + sqmr_pkg::POS_W'(1);
      end
    end
  end

  // Column address tracks the read address minus one row stride
  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      addr_r <= rd_addr - sqmr_pkg::ADDR_W'(side);
    end
  end

  // Element store: write on load, registered read on fetch
  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      mem[load_cnt_r[sqmr_pkg::ADDR_W-1:0]] <= load_value;
    end
    if (cmd.fetch) begin
      rdata_r     <= mem[rd_addr];
      last_pend_r <= last;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.zero_res) begin
      value_r <= '0;
      last_r  <= 1'b0;
      ok_r    <= 1'b0;
    end else if (cmd.capture) begin
      value_r <= rdata_r;
      last_r  <= last_pend_r;
      ok_r    <= 1'b1;
    end
  end

endmodule

// ===== hdl/square_matrix_rotate_90.sv =====
// ----------------------------------------------------------------------------
// square_matrix_rotate_90
// Rotates an N by N matrix of signed 32-bit words 90 degrees clockwise.
// ----------------------------------------------------------------------------
// Load transfers (in_tuser = 0) fill the element store in row-major order;
// once all N*N words are held, each fetch transfer (in_tuser = 1) returns the
// next word of the rotated matrix in row-major order, with tlast on the final
// one, after which a fresh matrix may be loaded. Loads into a full matrix are
// dropped until the rotated matrix has been fetched. A fetch before the matrix
// is complete returns zero with tuser low and moves nothing. A served fetch
// holds the input off while the single port element store's registered
// read passes through the read state into the output register. The input
// also holds off while a result waits in the output register and
// out_tready is low. Writing matrix_size
// (byte address 0; 0 acts as 1, values above 16 as 16) restarts both
// counters; write it only while no transfer is in flight. The store has no
// clearing pass: it is never read before it has been filled.
// ----------------------------------------------------------------------------
module square_matrix_rotate_90 (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic signed [sqmr_pkg::DATA_W-1:0]  in_tdata,   // [31:0] load_value
  input  logic                                in_tuser,   // [0] func
  // Result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic signed [sqmr_pkg::DATA_W-1:0]  out_tdata,  // [31:0] out_value
  output logic                                out_tlast,  // out_last
  output logic                                out_tuser,  // [0] out_ready
  // Configuration port
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [sqmr_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [sqmr_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [sqmr_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);

  sqmr_pkg::cmd_t    cmd;
  sqmr_pkg::status_t sts;

  logic                          cfg_wr;
  logic                          reg_sel;
  logic [sqmr_pkg::SIZE_W-1:0]   matrix_size;

  // Decode on the word address; low byte bits are ignored
  assign reg_sel    = (cfg_paddr[sqmr_pkg::CFG_ADDR_W-1:2] ==
                       sqmr_pkg::REG_MATRIX_SIZE[sqmr_pkg::CFG_ADDR_W-1:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_sel;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = reg_sel ? sqmr_pkg::CFG_DATA_W'(matrix_size) : '0;

  sqmr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_func    (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  sqmr_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_wr      (cfg_wr),
    .cfg_size    (cfg_pwdata[sqmr_pkg::SIZE_W-1:0]),
    .matrix_size (matrix_size),
    .load_value  (in_tdata),
    .out_value   (out_tdata),
    .out_last    (out_tlast),
    .out_ok      (out_tuser)
  );

endmodule

// ===== tb/sqmr_rotate_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqmr_rotate_checker
// Predicts and checks every result of the matrix rotate block.
// ----------------------------------------------------------------------------
// Watches the input, result and configuration ports at each rising edge.
// It keeps its own copy of the element store, counters and side length, and
// queues one expected result per fetch. Each result transfer is compared
// field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module sqmr_rotate_checker
  import sqmr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [DATA_W-1:0]     in_tdata,
  input  logic                  in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [DATA_W-1:0]     out_tdata,
  input  logic                  out_tlast,
  input  logic                  out_tuser,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  input  logic [CFG_DATA_W-1:0] cfg_prdata,
  input  logic                  cfg_pready,
  output int                    mismatches,
  output int                    awaited
);

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              last;
    logic              full;
  } rot_word_t;

  logic [DATA_W-1:0] shadow_store [DEPTH];
  logic [SIZE_W-1:0] size_reg;
  int unsigned       loaded;
  int unsigned       row;
  int unsigned       col;
  rot_word_t         rotated_q [$];
  int                errs = 0;
  int                queued = 0;

  assign mismatches = errs;
  assign awaited    = queued;

  function automatic int unsigned side_len(logic [SIZE_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > MAX_SIDE) return MAX_SIDE;
    return int'(v);
  endfunction

  task automatic flag(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    errs++;
  endtask

  task automatic restart();
    loaded = 0;
    row    = 0;
    col    = 0;
  endtask

  task automatic take_item(input logic func, input logic [DATA_W-1:0] data);
    int unsigned n;
    int unsigned total;
    rot_word_t   w;
    n     = side_len(size_reg);
    total = n * n;
    w     = '0;
    if (func == FUNC_LOAD) begin
      // drop loads into a full matrix
      if (loaded < total) begin
        shadow_store[ADDR_W'(loaded)] = data;
        loaded++;
      end
    end else if (loaded < total) begin
      rotated_q.push_back(w);
    end else begin
      // rotated (r, c) comes from original (N-1-c, r)
      w.value = shadow_store[ADDR_W'((n - 1 - col) * n + row)];
      w.last  = (row == n - 1) && (col == n - 1);
      w.full  = 1'b1;
      rotated_q.push_back(w);
      if (w.last) begin
        restart();
      end else if (col + 1 >= n) begin
        col = 0;
        row++;
      end else begin
        col++;
      end
    end
  endtask

  task automatic take_result();
    rot_word_t w;
    if (rotated_q.size() == 0) begin
      flag($sformatf("result %h with no fetch awaiting it", out_tdata));
    end else begin
      w = rotated_q.pop_front();
      if (out_tdata !== w.value)
        flag($sformatf("out_value got %h want %h", out_tdata, w.value));
      if (out_tlast !== w.last)
        flag($sformatf("out_last got %b want %b", out_tlast, w.last));
      if (out_tuser !== w.full)
        flag($sformatf("out_ready got %b want %b", out_tuser, w.full));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      size_reg = SIZE_W'(SIZE_RESET);
      restart();
      rotated_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr == REG_MATRIX_SIZE) begin
        if (cfg_pwrite) begin
          size_reg = cfg_pwdata[SIZE_W-1:0];
          restart();
        end else if (cfg_prdata !== CFG_DATA_W'(size_reg)) begin
          flag($sformatf("matrix_size read %h want %h", cfg_prdata, size_reg));
        end
      end
      // results never stem from an item taken at the same edge
      if (out_tvalid && out_tready) take_result();
      if (in_tvalid && in_tready) take_item(in_tuser, in_tdata);
    end
    queued <= rotated_q.size();
  end

endmodule

// ===== tb/tb_square_matrix_rotate_90.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_square_matrix_rotate_90
// Stimulus and verdict for the 90 degree matrix rotate block.
// ----------------------------------------------------------------------------
// Drives load and fetch transfers at a range of side lengths, with random
// gaps on both streams, a long result hold-off and pauses to drain. All
// prediction and comparison sits in the checker instantiated beside the block.
// ----------------------------------------------------------------------------
module tb_square_matrix_rotate_90;
  import sqmr_pkg::*;

  localparam int ITEM_TARGET    = 1400;
  localparam int SETTLE_CYCLES  = 8;    // covers the registered fetch path
  localparam int LONG_HOLD      = 200;  // result side hold-off under pressure
  localparam int WATCHDOG_LIMIT = 2000; // cycles without any transfer

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [DATA_W-1:0]     in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [DATA_W-1:0]     out_tdata;
  logic                  out_tlast;
  logic                  out_tuser;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int mismatches;
  int awaited;
  int sent = 0;
  int stalls = 0;
  bit tx_quiet = 1'b0;  // sender offers back to back
  bit rx_quiet = 1'b0;  // receiver always ready
  bit hold_long = 1'b0; // ask the receiver for one long hold-off

  square_matrix_rotate_90 i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  sqmr_rotate_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .mismatches  (mismatches),
    .awaited     (awaited)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Abort when nothing has moved on any port for far longer than the
  // slowest correct run ever stays silent.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
      stalls <= 0;
    end else begin
      stalls <= stalls + 1;
    end
    if (stalls >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: draw a hold-off per transfer; switch now and then into a
  // stretch of constant readiness, and honour a long hold-off on request.
  initial begin : result_sink
    int hold;
    out_tready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_long) begin
        hold_long = 1'b0;
        hold      = LONG_HOLD;
      end else begin
        hold = rx_quiet ? 0 : $urandom_range(0, 11);
      end
      if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
      if (hold > 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Mostly random words, with the signed extremes mixed in.
  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 15))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Offer one item after a random gap and hold it until the transfer.
  // tvalid stays high on return so a back-to-back item needs no toggle.
  task automatic push_item(input logic func, input logic [DATA_W-1:0] word,
                           input bit counted);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    if (counted) sent++;
  endtask

  // Stop offering and wait until every expected result has come back,
  // then let the block settle before touching the register.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write matrix_size, then read it back; the checker compares the read.
  task automatic set_size(input logic [SIZE_W-1:0] sz);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= REG_MATRIX_SIZE;
    cfg_pwdata  <= CFG_DATA_W'(sz);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // One matrix: N*N loads then N*N fetches. An untidy pass sprinkles early
  // fetches among the loads and dropped loads among the fetches. A squeeze
  // pass fires the fetches back to back under a long result hold-off.
  task automatic run_matrix(input int n, input bit tidy, input bit squeeze);
    int k;
    for (k = 0; k < n * n; k++) begin
      if (!tidy && $urandom_range(0, 9) == 0) push_item(FUNC_FETCH, pick_word(), 1'b1);
      push_item(FUNC_LOAD, pick_word(), 1'b1);
    end
    if (!tidy && $urandom_range(0, 1) == 0) push_item(FUNC_LOAD, pick_word(), 1'b0);
    if (squeeze) begin
      hold_long = 1'b1;
      tx_quiet  = 1'b1;
    end
    for (k = 0; k < n * n; k++) begin
      if (!tidy && $urandom_range(0, 9) == 0) push_item(FUNC_LOAD, pick_word(), 1'b0);
      push_item(FUNC_FETCH, pick_word(), 1'b1);
    end
    if (squeeze) tx_quiet = 1'b0;
  endtask

  initial begin : stimulus
    int               phase;
    int               n;
    int               reps;
    logic [SIZE_W-1:0] sz;

    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tuser    <= FUNC_LOAD;
    in_tdata    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= REG_MATRIX_SIZE;
    cfg_pwdata  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Fetch straight after reset: nothing loaded yet.
    push_item(FUNC_FETCH, 32'hFFFF_FFFF, 1'b1);
    drain();

    // Size zero acts as one; the second load hits a full matrix and drops.
    set_size('0);
    push_item(FUNC_LOAD, 32'h8000_0000, 1'b1);
    push_item(FUNC_LOAD, 32'h7FFF_FFFF, 1'b0);
    push_item(FUNC_FETCH, 32'h0000_0000, 1'b1);
    push_item(FUNC_FETCH, 32'h0000_0000, 1'b1);
    drain();

    // Two by two with both signed extremes, minus one and one in the corners.
    set_size(SIZE_W'(2));
    push_item(FUNC_LOAD, 32'h8000_0000, 1'b1);
    push_item(FUNC_LOAD, 32'h7FFF_FFFF, 1'b1);
    push_item(FUNC_LOAD, 32'hFFFF_FFFF, 1'b1);
    push_item(FUNC_LOAD, 32'h0000_0001, 1'b1);
    repeat (4) push_item(FUNC_FETCH, 32'h0000_0000, 1'b1);
    drain();

    // Rewrite the size part way through a load: counters restart.
    set_size(SIZE_W'(3));
    push_item(FUNC_LOAD, 32'h1234_5678, 1'b1);
    push_item(FUNC_LOAD, 32'h9ABC_DEF0, 1'b1);
    drain();
    set_size(SIZE_W'(3));
    push_item(FUNC_FETCH, 32'h0000_0000, 1'b1);
    drain();

    // Pressure: hold results off for a long stretch while fetches keep
    // coming, so the output register fills and the input stalls.
    set_size(SIZE_W'(4));
    run_matrix(4, 1'b1, 1'b1);
    drain();

    // Random phases. The first uses a size above the maximum (clamped),
    // the second the exact maximum with a matrix abandoned partly loaded.
    phase = 0;
    while (sent < ITEM_TARGET) begin
      if (phase == 0) begin
        sz = SIZE_W'(31);
      end else if (phase == 1) begin
        sz = SIZE_W'(MAX_SIDE);
      end else if ($urandom_range(0, 15) == 0) begin
        sz = SIZE_W'($urandom_range(7, 12));
      end else begin
        sz = SIZE_W'($urandom_range(0, 6));
      end
      n = (int'(sz) == 0) ? 1 : ((int'(sz) > MAX_SIDE) ? MAX_SIDE : int'(sz));
      drain();
      set_size(sz);
      if (phase == 1) begin
        repeat ($urandom_range(1, 40)) push_item(FUNC_LOAD, pick_word(), 1'b1);
        push_item(FUNC_FETCH, pick_word(), 1'b1);
      end else begin
        reps = (n > 8) ? 1 : $urandom_range(1, 4);
        repeat (reps) begin
          tx_quiet = ($urandom_range(0, 3) == 0);
          run_matrix(n, $urandom_range(0, 9) < 7, 1'b0);
        end
        tx_quiet = 1'b0;
        // ragged tail of mixed items, left for the next size write to cut
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 12))
            push_item(logic'($urandom_range(0, 1)), pick_word(), 1'b1);
        end
      end
      phase++;
    end

    drain();
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
